[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[sv/itar_pkg.sv]
// ----------------------------------------------------------------------------
// itar_pkg
// Types, constants and helper functions for the integer to ASCII converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itar_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int CNT_W      = $clog2(DATA_WIDTH);
	localparam int MAX_DIGITS = 64;
	localparam int ADDR_W     = $clog2(MAX_DIGITS);
	localparam int LEN_W      = 7;
	localparam int RADIX_W    = 6;
	localparam int CHAR_W     = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

	localparam int MODE_UNSIGNED_BIT = 0;
	localparam int MODE_WIDE_BIT     = 1;

	typedef struct packed {
		logic [63:0] value;
		logic [1:0]  mode;
	} itar_in_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_out;
		logic              last;
		logic [LEN_W-1:0]  length;
	} itar_out_t;

	typedef struct packed {
		logic done;
		logic zero;
	} itar_div_sts_t;

	function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 6'd10) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_A + CHAR_W'(d) - 8'd10;
		end
		return c;
	endfunction

endpackage

[sv/integer_to_ascii_radix.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts one integer to its ASCII digits in a programmable radix.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each digit costs one pass of
// the shared bit-serial divider, and each character is then read back from the digit buffer
// (ST_RD, then ST_OUT), with a minus sign sent from ST_SIGN ahead of the digits. Characters
// come out most significant first on result, each for one cycle with result_strobe high;
// the last one is shown in the first cycle with busy low, and the receiver must take them
// as they come.
`timescale 1ns / 1ps

module integer_to_ascii_radix (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  itar_pkg::itar_in_t            operand,
	output logic                          result_strobe,
	output itar_pkg::itar_out_t           result,
	input  logic                          cfg_we,
	input  logic [itar_pkg::RADIX_W-1:0]  cfg_wdata
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_SIGN = 5'b00100,
		ST_RD   = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [itar_pkg::RADIX_W-1:0]    radix_q;
	logic                            neg_q;
	logic [itar_pkg::ADDR_W:0]       nd_q;
	logic [itar_pkg::ADDR_W-1:0]     rd_ptr_q;
	logic                            strobe_q;
	itar_pkg::itar_out_t             result_q;

	logic                            accept;
	logic [itar_pkg::RADIX_W-1:0]    radix_eff;
	logic [itar_pkg::DATA_WIDTH-1:0] sel_val;
	logic                            sign_bit;
	logic                            is_neg;
	logic [itar_pkg::DATA_WIDTH-1:0] neg_val;
	logic [itar_pkg::DATA_WIDTH-1:0] start_val;
	logic                            div_load;
	logic [itar_pkg::DATA_WIDTH-1:0] div_dividend;
	logic [itar_pkg::DATA_WIDTH-1:0] div_quotient;
	logic [itar_pkg::RADIX_W-1:0]    div_rem;
	itar_pkg::itar_div_sts_t         div_sts;
	logic                            buf_we;
	logic [itar_pkg::CHAR_W-1:0]     buf_rdata;
	logic [itar_pkg::LEN_W-1:0]      total;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign radix_eff = itar_pkg::eff_radix(radix_q);

	always_comb begin
		if (operand.mode[itar_pkg::MODE_WIDE_BIT]) begin
			sel_val  = operand.value[itar_pkg::DATA_WIDTH-1:0];
			sign_bit = sel_val[itar_pkg::DATA_WIDTH-1];
			neg_val  = ~sel_val + 1'b1;
		end else begin
			sel_val  = itar_pkg::DATA_WIDTH'(operand.value[31:0]);
			sign_bit = sel_val[31];
			neg_val  = itar_pkg::DATA_WIDTH'(32'(~sel_val[31:0] + 32'd1));
		end
		is_neg    = !operand.mode[itar_pkg::MODE_UNSIGNED_BIT] && sign_bit &&
			(radix_eff == itar_pkg::RADIX_DEC);
		start_val = is_neg ? neg_val : sel_val;
	end

	assign div_load     = accept || ((state_q == ST_DIV) && div_sts.done && !div_sts.zero);
	assign div_dividend = accept ? start_val : div_quotient;
	assign buf_we       = (state_q == ST_DIV) && div_sts.done;
	assign total        = itar_pkg::LEN_W'(nd_q) + itar_pkg::LEN_W'(neg_q);

	itar_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (div_load),
		.dividend  (div_dividend),
		.divisor   (radix_eff),
		.quotient  (div_quotient),
		.remainder (div_rem),
		.status    (div_sts)
	);

	itar_ram #(
		.WIDTH (itar_pkg::CHAR_W),
		.DEPTH (itar_pkg::MAX_DIGITS)
	) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (nd_q[itar_pkg::ADDR_W-1:0]),
		.wdata (itar_pkg::digit_char(div_rem)),
		.raddr (rd_ptr_q),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			radix_q  <= itar_pkg::RADIX_RESET;
			neg_q    <= 1'b0;
			nd_q     <= '0;
			rd_ptr_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						neg_q   <= is_neg;
						nd_q    <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_sts.done) begin
						nd_q <= nd_q + 1'b1;
						if (div_sts.zero) begin
							rd_ptr_q <= nd_q[itar_pkg::ADDR_W-1:0];
							state_q  <= neg_q ? ST_SIGN : ST_RD;
						end
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					state_q  <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					strobe_q <= 1'b1;
					if (rd_ptr_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rd_ptr_q <= rd_ptr_q - 1'b1;
						state_q  <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SIGN) begin
			result_q.char_out <= itar_pkg::CHAR_MINUS;
			result_q.last     <= 1'b0;
			result_q.length   <= '0;
		end else if (state_q == ST_OUT) begin
			result_q.char_out <= buf_rdata;
			result_q.last     <= (rd_ptr_q == '0);
			result_q.length   <= (rd_ptr_q == '0) ? total : '0;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

endmodule

[sv/itar_ram.sv]
// ----------------------------------------------------------------------------
// itar_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[sv/itar_div.sv]
// ----------------------------------------------------------------------------
// itar_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itar_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic [itar_pkg::DATA_WIDTH-1:0]      dividend,
	input  logic [itar_pkg::RADIX_W-1:0]         divisor,
	output logic [itar_pkg::DATA_WIDTH-1:0]      quotient,
	output logic [itar_pkg::RADIX_W-1:0]         remainder,
	output itar_pkg::itar_div_sts_t              status
);

	logic [itar_pkg::DATA_WIDTH-1:0] quo_q;
	logic [itar_pkg::RADIX_W-1:0]    rem_q;
	logic [itar_pkg::RADIX_W-1:0]    dvs_q;
	logic [itar_pkg::CNT_W-1:0]      cnt_q;
	logic                            run_q;
	logic                            done_q;
	logic [itar_pkg::RADIX_W:0]      trial;
	logic                            ge;
	logic [itar_pkg::RADIX_W:0]      diff;

	assign trial = {rem_q, quo_q[itar_pkg::DATA_WIDTH-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == itar_pkg::CNT_W'(itar_pkg::DATA_WIDTH - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[itar_pkg::DATA_WIDTH-2:0], ge};
			rem_q <= ge ? diff[itar_pkg::RADIX_W-1:0] : trial[itar_pkg::RADIX_W-1:0];
		end
	end

	assign quotient    = quo_q;
	assign remainder   = rem_q;
	assign status.done = done_q;
	assign status.zero = (quo_q == '0);

endmodule

[sv/itar_check.sv]
// ----------------------------------------------------------------------------
// itar_check
// Port-level checks for the integer to ASCII converter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itar_check (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                result_strobe,
	input itar_pkg::itar_out_t result
);

	logic char_ok;

	assign char_ok = (result.char_out == itar_pkg::CHAR_MINUS) ||
		((result.char_out >= itar_pkg::CHAR_ZERO) &&
		(result.char_out <= itar_pkg::CHAR_ZERO + 8'd9)) ||
		((result.char_out >= itar_pkg::CHAR_A) &&
		(result.char_out <= itar_pkg::CHAR_A + 8'd25));

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_SAME(a_mid_char_busy, clk, arst_n, result_strobe && !result.last, busy)
	`ASSERT_SAME(a_last_length, clk, arst_n, result_strobe && result.last, result.length != '0)
	`ASSERT_SAME(a_end_last, clk, arst_n, $fell(busy), result_strobe && result.last)
	`ASSERT_SAME(a_char_set, clk, arst_n, result_strobe, char_ok)

endmodule

bind integer_to_ascii_radix itar_check u_itar_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.result        (result)
);
